@@ src/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8u16_pkg;

  // Lead byte ranges and fixed bit patterns
  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD2_LO      = 8'hC2;
  localparam logic [7:0]  LEAD2_HI      = 8'hDF;
  localparam logic [7:0]  LEAD3_LO      = 8'hE0;
  localparam logic [7:0]  LEAD3_HI      = 8'hEF;
  localparam logic [7:0]  LEAD3_SURR    = 8'hED;
  localparam logic [7:0]  LEAD4_LO      = 8'hF0;
  localparam logic [7:0]  LEAD4_HI      = 8'hF4;
  localparam logic [1:0]  CONT_TAG      = 2'b10;
  localparam logic [7:0]  SECOND_A0     = 8'hA0;
  localparam logic [7:0]  SECOND_90     = 8'h90;
  localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;  // 0xDC00 >> 10
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  // Output queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Extra bound on the byte that follows a lead byte
  typedef enum logic [2:0] {
    BND_NONE  = 3'd0,
    BND_GE_A0 = 3'd1,  // after E0: no overlong 3-byte form
    BND_LE_9F = 3'd2,  // after ED: no surrogate
    BND_GE_90 = 3'd3,  // after F0: no overlong 4-byte form
    BND_LE_8F = 3'd4   // after F4: nothing above 10FFFF
  } bound_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        status;
    logic        end_of_string;
  } res_t;

  // Results produced by one byte, handed to the output queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

@@ src/utf8_to_utf16_transcoder.sv @@
// Top level: input byte register, decoder and result queue.
// Depends on u8u16_pkg, u8u16_decode, u8u16_outq.
//
//   channel  ports                                        dir
//   -------  -------------------------------------------  ---
//   input    in_valid in_ready in_byte_in in_final_byte   in
//   result   out_valid out_ready out_code_unit            out
//            out_status out_end_of_string
//
// One byte per cycle sustained while the queue has room. A byte is held in
// the input register, is decoded and lands in a four-entry result queue,
// from whose head its first result is offered on the output. A surrogate
// pair fills two queue entries at once; the queue drains one result per
// cycle while out_ready is high. Input stalls when under two entries are free.
// Synchronous active-low reset clears all decode state and empties the queue.
`default_nettype none

module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_code_unit,
  output logic             out_status,
  output logic             out_end_of_string
);

  logic         in_vld_r;
  logic [7:0]   byte_r;
  logic         fin_r;
  logic         take;
  logic         room;
  push_t        push;
  res_t         head;
  logic [QAW:0] q_count;

  assign take     = in_vld_r && room;
  assign in_ready = !in_vld_r || take;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte_in;
      fin_r  <= in_final_byte;
    end
  end

  u8u16_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .byte_in    (byte_r),
    .final_byte (fin_r),
    .push       (push)
  );

  u8u16_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .q_valid (out_valid),
    .q_ready (out_ready),
    .q_head  (head),
    .q_count (q_count)
  );

  assign out_code_unit     = head.code_unit;
  assign out_status        = head.status;
  assign out_end_of_string = head.end_of_string;

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_pair_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> !push.r0.end_of_string && !push.r0.status)
    else $error("first half of a surrogate pair marked end or error");

  a_pair_high: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.r0.code_unit[15:10] == HI_SURR_TAG
                       && push.r1.code_unit[15:10] == LO_SURR_TAG)
    else $error("surrogate pair halves malformed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_code_unit == 16'd0)
    else $error("error result carries a nonzero code unit");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> take)
    else $error("results pushed without an accepted byte");

endmodule

`default_nettype wire

@@ src/u8u16_decode.sv @@
// Per-byte UTF-8 decode state and result generation.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_decode import u8u16_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] byte_in,
  input  wire logic       final_byte,
  output push_t           push
);

  logic [1:0]  pending_r, pending_nxt;
  logic [20:0] partial_r, partial_nxt;
  bound_t      bound_r, bound_nxt;
  logic        at_second_r, at_second_nxt;
  logic        err_r, err_nxt;

  logic        bound_fail;
  logic        bad;
  logic        done;
  logic [20:0] cp;
  logic [20:0] shifted;
  logic [19:0] v;
  logic        clear;
  res_t        err_res;

  // Second-byte bound check
  always_comb begin
    bound_fail = 1'b0;
    unique case (bound_r)
      BND_GE_A0: bound_fail = byte_in <  SECOND_A0;
      BND_LE_9F: bound_fail = byte_in >= SECOND_A0;
      BND_GE_90: bound_fail = byte_in <  SECOND_90;
      BND_LE_8F: bound_fail = byte_in >= SECOND_90;
      default:   bound_fail = 1'b0;
    endcase
  end

  assign shifted = {partial_r[14:0], byte_in[5:0]};

  // Byte classification and next state
  always_comb begin
    pending_nxt   = pending_r;
    partial_nxt   = partial_r;
    bound_nxt     = bound_r;
    at_second_nxt = at_second_r;
    err_nxt       = err_r;
    bad           = 1'b0;
    done          = 1'b0;
    cp            = '0;
    if (pending_r == 2'd0) begin
      if (byte_in < ASCII_LIMIT) begin
        cp   = {13'd0, byte_in};
        done = 1'b1;
      end else if (byte_in >= LEAD2_LO && byte_in <= LEAD2_HI) begin
        partial_nxt   = {16'd0, byte_in[4:0]};
        pending_nxt   = 2'd1;
        bound_nxt     = BND_NONE;
        at_second_nxt = 1'b1;
      end else if (byte_in >= LEAD3_LO && byte_in <= LEAD3_HI) begin
        partial_nxt   = {17'd0, byte_in[3:0]};
        pending_nxt   = 2'd2;
        bound_nxt     = (byte_in == LEAD3_LO)   ? BND_GE_A0 :
                        (byte_in == LEAD3_SURR) ? BND_LE_9F : BND_NONE;
        at_second_nxt = 1'b1;
      end else if (byte_in >= LEAD4_LO && byte_in <= LEAD4_HI) begin
        partial_nxt   = {18'd0, byte_in[2:0]};
        pending_nxt   = 2'd3;
        bound_nxt     = (byte_in == LEAD4_LO) ? BND_GE_90 :
                        (byte_in == LEAD4_HI) ? BND_LE_8F : BND_NONE;
        at_second_nxt = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (byte_in[7:6] != CONT_TAG) begin
        bad = 1'b1;
      end else if (at_second_r && bound_fail) begin
        bad = 1'b1;
      end else begin
        partial_nxt   = shifted;
        pending_nxt   = pending_r - 2'd1;
        at_second_nxt = 1'b0;
        if (pending_r == 2'd1) begin
          cp   = shifted;
          done = 1'b1;
        end
      end
    end
    if (done) begin
      partial_nxt   = '0;
      bound_nxt     = BND_NONE;
      at_second_nxt = 1'b0;
    end
    if (bad) begin
      err_nxt = 1'b1;
    end
  end

  assign v = 20'(cp - SUPP_BASE);

  // Results for this byte
  always_comb begin
    err_res = '{code_unit: 16'd0, status: 1'b1, end_of_string: final_byte};
    push    = '{n: 2'd0, r0: err_res, r1: err_res};
    if (err_r) begin
      push.n = final_byte ? 2'd1 : 2'd0;
    end else if (bad) begin
      push.n = 2'd1;
    end else if (done) begin
      if (cp[20:16] == 5'd0) begin
        push.n  = 2'd1;
        push.r0 = '{code_unit: cp[15:0], status: 1'b0, end_of_string: final_byte};
      end else begin
        push.n  = 2'd2;
        push.r0 = '{code_unit: {HI_SURR_TAG, v[19:10]}, status: 1'b0,
                    end_of_string: 1'b0};
        push.r1 = '{code_unit: {LO_SURR_TAG, v[9:0]}, status: 1'b0,
                    end_of_string: final_byte};
      end
    end else if (final_byte) begin
      // string cut short
      push.n = 2'd1;
    end
    if (!take) begin
      push.n = 2'd0;
    end
  end

  assign clear = final_byte;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 2'd0;
      partial_r   <= '0;
      bound_r     <= BND_NONE;
      at_second_r <= 1'b0;
      err_r       <= 1'b0;
    end else if (take) begin
      if (clear) begin
        pending_r   <= 2'd0;
        partial_r   <= '0;
        bound_r     <= BND_NONE;
        at_second_r <= 1'b0;
        err_r       <= 1'b0;
      end else if (!err_r) begin
        pending_r   <= pending_nxt;
        partial_r   <= partial_nxt;
        bound_r     <= bound_nxt;
        at_second_r <= at_second_nxt;
        err_r       <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/u8u16_outq.sv @@
// Small result queue: takes up to two results a cycle, gives one if q_ready.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_outq import u8u16_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire push_t push,
  output logic      room,
  output logic      q_valid,
  input  wire logic q_ready,
  output res_t      q_head,
  output logic [QAW:0] q_count
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           pop;

  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign pop     = q_valid && q_ready;
  assign room    = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign q_count = cnt_r;
  assign cnt_nxt = cnt_r + {{(QAW-1){1'b0}}, push.n} - {{QAW{1'b0}}, pop};

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + QAW'(1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
